// File: design/wac_pkg.sv
// Shared types and constants of the water autotile classifier.
package wac_pkg;

  localparam int MAX_WIDTH    = 32;
  localparam int MAX_HEIGHT   = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int TILE_W       = 3;
  localparam int IDX_W        = 4;
  localparam int WIDTH_REG_W  = 6;
  localparam int HEIGHT_REG_W = 11;
  localparam int CFG_DATA_W   = 11;

  typedef logic [TILE_W-1:0] tile_t;
  typedef tile_t [2:0] tile_row_t;
  typedef tile_row_t [2:0] hood_t;

  typedef struct packed {
    tile_t older;
    tile_t newer;
  } line_pair_t;

  typedef struct packed {
    logic      valid;
    tile_row_t col;
  } win_shift_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } item_t;

  typedef enum logic [1:0] {
    SLOT_MID    = 2'b00,
    SLOT_RIGHT  = 2'b01,
    SLOT_BOTTOM = 2'b10,
    SLOT_CORNER = 2'b11
  } slot_t;

endpackage

// File: design/wac_line_store.sv
// Column-addressed line store holding the two previous map rows.
module wac_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [wac_pkg::COL_W-1:0] rd_addr,
  output wac_pkg::line_pair_t       rd_data,
  input  logic                      wr_en,
  input  logic [wac_pkg::COL_W-1:0] wr_addr,
  input  wac_pkg::line_pair_t       wr_data
);
  import wac_pkg::*;

  line_pair_t row_store [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_store[rd_addr];
    end
  end

endmodule

// File: design/wac_window.sv
// 3x3 window registers and neighbourhood classification.
module wac_window (
  input  logic                      clk,
  input  wac_pkg::win_shift_t       shift,
  input  wac_pkg::item_t            item,
  input  wac_pkg::slot_t            slot,
  output logic [wac_pkg::IDX_W-1:0] slot_idx,
  output logic [wac_pkg::IDX_W-1:0] right_idx
);
  import wac_pkg::*;

  localparam tile_t TILE_PATH  = 3'd1;
  localparam tile_t TILE_WATER = 3'd2;
  localparam tile_t TILE_ROCK  = 3'd4;

  localparam logic [IDX_W-1:0] IDX_GRASS  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_PATH   = 4'd1;
  localparam logic [IDX_W-1:0] IDX_CENTRE = 4'd2;
  localparam logic [IDX_W-1:0] IDX_N      = 4'd3;
  localparam logic [IDX_W-1:0] IDX_S      = 4'd4;
  localparam logic [IDX_W-1:0] IDX_W_EDGE = 4'd5;
  localparam logic [IDX_W-1:0] IDX_E      = 4'd6;
  localparam logic [IDX_W-1:0] IDX_NW     = 4'd7;
  localparam logic [IDX_W-1:0] IDX_NE     = 4'd8;
  localparam logic [IDX_W-1:0] IDX_SE     = 4'd9;
  localparam logic [IDX_W-1:0] IDX_SW     = 4'd10;
  localparam logic [IDX_W-1:0] IDX_FREE   = 4'd11;
  localparam logic [3:0]       MIN_WET    = 4'd4;

  typedef struct packed {
    logic n;
    logic s;
    logic w;
    logic e;
  } bound_t;

  hood_t window_cells;

  // shift or clamp the window so the chosen cell sits in the middle
  function automatic hood_t pick(input hood_t win, input logic ro, input logic co);
    hood_t rows;
    hood_t hd;
    rows[0] = ro ? win[1] : win[0];
    rows[1] = ro ? win[2] : win[1];
    rows[2] = win[2];
    for (int r = 0; r < 3; r++) begin
      hd[r][0] = co ? rows[r][1] : rows[r][0];
      hd[r][1] = co ? rows[r][2] : rows[r][1];
      hd[r][2] = rows[r][2];
    end
    return hd;
  endfunction

  function automatic logic [IDX_W-1:0] classify(input hood_t hd, input bound_t b);
    logic [2:0][2:0] wet;
    logic [3:0]      cnt;
    logic            n;
    logic            s;
    logic            we;
    logic            e;
    cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wet[r][c] = (hd[r][c] == TILE_WATER) && !(r == 0 && b.n) && !(r == 2 && b.s)
                    && !(c == 0 && b.w) && !(c == 2 && b.e);
        if (!(r == 1 && c == 1)) begin
          cnt = cnt + 4'(wet[r][c]);
        end
      end
    end
    n  = wet[0][1];
    s  = wet[2][1];
    we = wet[1][0];
    e  = wet[1][2];
    if (hd[1][1] != TILE_WATER) begin
      if (hd[1][1] == TILE_PATH) return IDX_PATH;
      if (hd[1][1] == TILE_ROCK) return IDX_FREE;
      return IDX_GRASS;
    end
    if (cnt < MIN_WET) return IDX_GRASS;
    if (!n && !we && e && s) return IDX_NW;
    if (!n && !e && we && s) return IDX_NE;
    if (!s && !e && we && n) return IDX_SE;
    if (!s && !we && e && n) return IDX_SW;
    if (!n && (s || e || we)) return IDX_N;
    if (!s && (n || e || we)) return IDX_S;
    if (!we && (n || s || e)) return IDX_W_EDGE;
    if (!e && (n || s || we)) return IDX_E;
    return IDX_CENTRE;
  endfunction

  always_ff @(posedge clk) begin
    if (shift.valid) begin
      for (int r = 0; r < 3; r++) begin
        window_cells[r][0] <= window_cells[r][1];
        window_cells[r][1] <= window_cells[r][2];
        window_cells[r][2] <= shift.col[r];
      end
    end
  end

  logic   ro;
  logic   co;
  bound_t slot_bound;
  bound_t right_bound;

  always_comb begin
    ro = slot[1];
    co = slot[0];
    slot_bound.n = ro ? (item.row == '0) : (item.row == ROW_W'(1));
    slot_bound.s = ro;
    slot_bound.w = co ? (item.col == '0) : (item.col == COL_W'(1));
    slot_bound.e = co;
    right_bound.n = (item.row == ROW_W'(1));
    right_bound.s = 1'b0;
    right_bound.w = (item.col == '0);
    right_bound.e = 1'b1;
    slot_idx  = classify(pick(window_cells, ro, co), slot_bound);
    right_idx = classify(pick(window_cells, 1'b0, 1'b1), right_bound);
  end

endmodule

// File: design/water_autotile_classifier.sv
// Top level of the water autotile classifier.
//
// Map cells enter on the s_ channel in raster order, one tile type per
// transfer. Each accepted cell completes up to four classified cells, which
// leave on the m_ channel as one transfer each; m_tlast marks the last result
// caused by an input cell, and a cell that completes nothing gives none.
// A cell is normally reported when the cell one row plus one column after it
// arrives; last-row cells come out as soon as their east neighbour arrives,
// and the final map cell flushes everything still open.
// An item goes through the line store read, the window update with the
// line store write-back, and then its results into the output register one
// after another. s_tready is high only in the idle state, so a new cell is
// taken only once the previous cell has registered its last result.
// The window update happens in ST_READ, and the first result is registered
// in the ST_EMIT state that follows, once the output register is free.
// A stalled receiver holds the output register; the next cell is still taken
// and its results wait until the register frees.
// Reset sets map_width and map_height to 32 and the position to the map's
// first cell. A write on the cfg port also restarts the position.
module water_autotile_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [2:0] tile_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // [4:0] cell_column, [14:5] cell_row,
                                                    // [18:15] atlas_index
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wac_pkg::*;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EMIT} state_t;

  function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_REG_W-1:0] v);
    if (v == '0) return '0;
    if (v > WIDTH_REG_W'(MAX_WIDTH)) return COL_W'(MAX_WIDTH - 1);
    return COL_W'(v - 1'b1);
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [HEIGHT_REG_W-1:0] v);
    if (v == '0) return '0;
    if (v > HEIGHT_REG_W'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT - 1);
    return ROW_W'(v - 1'b1);
  endfunction

  state_t           state;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] input_column;
  logic [ROW_W-1:0] input_row;
  item_t            item;
  tile_t            item_tile;
  logic             item_final;
  logic             item_lastrow;
  logic [3:0]       emit_mask;
  logic [IDX_W-1:0] pending_idx;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [IDX_W-1:0] out_idx;

  logic             accept;
  logic             pos_final;
  logic             out_free;
  line_pair_t       rd_data;
  line_pair_t       wr_data;
  win_shift_t       shift;
  slot_t            slot;
  logic [3:0]       slot_bit;
  logic [3:0]       mask_rest;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] right_idx;
  logic [COL_W-1:0] emit_col;
  logic [ROW_W-1:0] emit_row;
  logic [IDX_W-1:0] emit_idx;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign pos_final = (input_column == w_last) && (input_row == h_last);
  assign out_free  = !m_tvalid || m_tready;
  assign wr_data   = '{older: rd_data.newer, newer: item_tile};
  assign shift     = '{valid: (state == ST_READ),
                       col: {item_tile, rd_data.newer, rd_data.older}};
  assign m_tdata   = {5'd0, out_idx, out_row, out_col};

  wac_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (input_column),
    .rd_data (rd_data),
    .wr_en   (state == ST_READ),
    .wr_addr (item.col),
    .wr_data (wr_data)
  );

  wac_window u_window (
    .clk       (clk),
    .shift     (shift),
    .item      (item),
    .slot      (slot),
    .slot_idx  (slot_idx),
    .right_idx (right_idx)
  );

  always_comb begin
    priority if (emit_mask[0]) slot = SLOT_MID;
    else if (emit_mask[1]) slot = SLOT_RIGHT;
    else if (emit_mask[2]) slot = SLOT_BOTTOM;
    else slot = SLOT_CORNER;
    slot_bit  = 4'b0001 << slot;
    mask_rest = emit_mask & ~slot_bit;
    emit_idx  = slot_idx;
    unique case (slot)
      SLOT_MID: begin
        if (item.col == '0) begin
          emit_col = w_last;
          emit_row = item.row - ROW_W'(2);
          emit_idx = pending_idx;
        end else begin
          emit_col = item.col - COL_W'(1);
          emit_row = item.row - ROW_W'(1);
        end
      end
      SLOT_RIGHT: begin
        emit_col = item.col;
        emit_row = item.row - ROW_W'(1);
      end
      SLOT_BOTTOM: begin
        emit_col = item.col - COL_W'(1);
        emit_row = item.row;
      end
      default: begin
        emit_col = item.col;
        emit_row = item.row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      emit_mask    <= '0;
      w_last       <= COL_W'(31);
      h_last       <= ROW_W'(31);
      input_column <= '0;
      input_row    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:  w_last <= width_last(cfg_wdata[WIDTH_REG_W-1:0]);
          REG_MAP_HEIGHT: h_last <= height_last(cfg_wdata[HEIGHT_REG_W-1:0]);
          default: ;
        endcase
        input_column <= '0;
        input_row    <= '0;
      end else if (accept) begin
        item         <= '{col: input_column, row: input_row};
        item_tile    <= s_tdata[TILE_W-1:0];
        item_final   <= pos_final;
        item_lastrow <= (input_row == h_last);
        if (pos_final) begin
          input_column <= '0;
          input_row    <= '0;
        end else if (input_column == w_last) begin
          input_column <= '0;
          input_row    <= input_row + ROW_W'(1);
        end else begin
          input_column <= input_column + COL_W'(1);
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          emit_mask[0] <= ((item.col != '0) && (item.row != '0))
                          || ((item.col == '0) && (item.row > ROW_W'(1)));
          emit_mask[1] <= item_final && (item.row != '0);
          emit_mask[2] <= item_lastrow && (item.col != '0);
          emit_mask[3] <= item_final;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_mask == '0) begin
            if (item.col == w_last) pending_idx <= right_idx;
            state <= ST_IDLE;
          end else if (out_free) begin
            out_col   <= emit_col;
            out_row   <= emit_row;
            out_idx   <= emit_idx;
            m_tlast   <= (mask_rest == '0);
            m_tvalid  <= 1'b1;
            emit_mask <= mask_rest;
            if (mask_rest == '0) begin
              if (item.col == w_last) pending_idx <= right_idx;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted again before write-back");

  a_pos_in_map: assert property (@(posedge clk) disable iff (rst)
    (input_column <= w_last) && (input_row <= h_last))
    else $error("input position outside the map");

  a_flush_mask: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && emit_mask[1] |-> emit_mask[3])
    else $error("row-end flush without final cell");

  a_out_in_map: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_col <= w_last) && (out_row <= h_last))
    else $error("result position outside the map");

endmodule
